[design/capt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capacity table package
// Shared codes, field widths and the result record of the capacity table.
// ----------------------------------------------------------------------------
package capt_pkg;

	localparam int OPCODE_W = 2;
	localparam int OWNER_W  = 16;
	localparam int AMOUNT_W = 32;
	localparam int STATUS_W = 3;

	localparam logic [AMOUNT_W-1:0] CAP_RESET = 32'd4096;

	localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CHECK   = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_ZERO_AMOUNT  = 3'd1,
		ST_ID_PRESENT   = 3'd2,
		ST_INSUFFICIENT = 3'd3,
		ST_NOT_FOUND    = 3'd4,
		ST_TABLE_FULL   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_RESP
	} state_t;

	typedef struct packed {
		status_t             status;
		logic [AMOUNT_W-1:0] available;
		logic [AMOUNT_W-1:0] used;
		logic [AMOUNT_W-1:0] released_amount;
	} rsp_t;

endpackage

[design/capt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capacity table channels
// Request and response channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface capt_req_if;
	logic                           valid;
	logic                           ready;
	logic [capt_pkg::OPCODE_W-1:0]  opcode;
	logic [capt_pkg::OWNER_W-1:0]   owner_id;
	logic [capt_pkg::AMOUNT_W-1:0]  amount;

	modport source (output valid, output opcode, output owner_id, output amount, input ready);
	modport sink   (input valid, input opcode, input owner_id, input amount, output ready);
endinterface

interface capt_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [capt_pkg::STATUS_W-1:0]  status;
	logic [capt_pkg::AMOUNT_W-1:0]  available;
	logic [capt_pkg::AMOUNT_W-1:0]  used;
	logic [capt_pkg::AMOUNT_W-1:0]  released_amount;

	modport source (output valid, output status, output available, output used,
		output released_amount, input ready);
	modport sink   (input valid, input status, input available, input used,
		input released_amount, output ready);
endinterface

[design/capt_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capacity table entry memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module capt_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 48
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[design/capt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capacity table sequencer
// For a release or a nonzero allocate, scans the entry memory for the owner and a
// free slot; then updates the table and the used total and forms the result.
// ----------------------------------------------------------------------------
module capt_ctrl #(
	parameter int TABLE_ENTRIES = 16,
	parameter int ID_W          = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	capt_req_if.sink                               req,
	input  logic [capt_pkg::AMOUNT_W-1:0]          total_capacity,
	output capt_pkg::rsp_t                         res,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output logic                                   rd_en,
	output logic [(TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1)-1:0] rd_addr,
	input  logic [ID_W+capt_pkg::AMOUNT_W-1:0]     rd_data,
	output logic                                   wr_en,
	output logic [(TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1)-1:0] wr_addr,
	output logic [ID_W+capt_pkg::AMOUNT_W-1:0]     wr_data
);

	localparam int IDX_W = TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = IDX_W + 1;
	localparam int AMT_W = capt_pkg::AMOUNT_W;
	localparam int ENT_W = ID_W + AMT_W;

	capt_pkg::state_t  state_q, state_d;
	capt_pkg::status_t status_d, status_q;

	logic [capt_pkg::OPCODE_W-1:0] op_q;
	logic [ID_W-1:0]               id_q;
	logic [AMT_W-1:0]              amt_q;
	logic [CNT_W-1:0]              issue_q;
	logic                          chk_vld_s1;
	logic [IDX_W-1:0]              chk_idx_s1;
	logic                          match_q;
	logic [IDX_W-1:0]              match_idx_q;
	logic [AMT_W-1:0]              match_amt_q;
	logic                          free_q;
	logic [IDX_W-1:0]              free_idx_q;
	logic [TABLE_ENTRIES-1:0]      valid_q;
	logic [AMT_W-1:0]              used_q;
	logic [AMT_W-1:0]              freed_q;
	logic [AMT_W-1:0]              avail_now;
	logic                          fits;
	logic                          grant;
	logic                          drop;
	logic                          accept;
	logic                          needs_scan;
	logic                          hit;

	assign avail_now  = (total_capacity >= used_q) ? (total_capacity - used_q) : '0;
	assign fits       = (amt_q <= avail_now);
	assign accept     = req.valid && req.ready;
	assign needs_scan = (req.opcode == capt_pkg::OP_RELEASE) ||
		((req.opcode == capt_pkg::OP_ALLOC) && (req.amount != '0));
	assign hit        = valid_q[chk_idx_s1] && (rd_data[ENT_W-1:AMT_W] == id_q);
	assign rd_addr    = issue_q[IDX_W-1:0];

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		res_valid = 1'b0;
		rd_en     = 1'b0;
		unique case (state_q)
			capt_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = needs_scan ? capt_pkg::S_SCAN : capt_pkg::S_DECIDE;
				end
			end
			capt_pkg::S_SCAN: begin
				rd_en = (issue_q < CNT_W'(TABLE_ENTRIES));
				if (!rd_en && !chk_vld_s1) begin
					state_d = capt_pkg::S_DECIDE;
				end
			end
			capt_pkg::S_DECIDE: begin
				state_d = capt_pkg::S_RESP;
			end
			capt_pkg::S_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = capt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = capt_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		status_d = capt_pkg::ST_OK;
		grant    = 1'b0;
		drop     = 1'b0;
		case (op_q)
			capt_pkg::OP_ALLOC: begin
				if (amt_q == '0) begin
					status_d = capt_pkg::ST_ZERO_AMOUNT;
				end else if (match_q) begin
					status_d = capt_pkg::ST_ID_PRESENT;
				end else if (!fits) begin
					status_d = capt_pkg::ST_INSUFFICIENT;
				end else if (!free_q) begin
					status_d = capt_pkg::ST_TABLE_FULL;
				end else begin
					grant = 1'b1;
				end
			end
			capt_pkg::OP_RELEASE: begin
				if (!match_q) begin
					status_d = capt_pkg::ST_NOT_FOUND;
				end else begin
					drop = 1'b1;
				end
			end
			default: begin
				status_d = fits ? capt_pkg::ST_OK : capt_pkg::ST_INSUFFICIENT;
			end
		endcase
	end

	assign wr_en   = (state_q == capt_pkg::S_DECIDE) && grant;
	assign wr_addr = free_idx_q;
	assign wr_data = {id_q, amt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= capt_pkg::S_IDLE;
			issue_q    <= '0;
			chk_vld_s1 <= 1'b0;
			match_q    <= 1'b0;
			free_q     <= 1'b0;
			valid_q    <= '0;
			used_q     <= '0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= rd_en;
			if (accept) begin
				issue_q <= '0;
				match_q <= 1'b0;
				free_q  <= 1'b0;
			end
			if (rd_en) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			if (chk_vld_s1) begin
				if (hit) begin
					match_q <= 1'b1;
				end
				if (!valid_q[chk_idx_s1]) begin
					free_q <= 1'b1;
				end
			end
			if (state_q == capt_pkg::S_DECIDE) begin
				if (grant) begin
					valid_q[free_idx_q] <= 1'b1;
					used_q              <= used_q + amt_q;
				end
				if (drop) begin
					valid_q[match_idx_q] <= 1'b0;
					used_q <= (used_q >= match_amt_q) ? (used_q - match_amt_q) : '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_addr;
		if (accept) begin
			op_q  <= req.opcode;
			id_q  <= req.owner_id[ID_W-1:0];
			amt_q <= req.amount;
		end
		if (chk_vld_s1) begin
			if (hit && !match_q) begin
				match_idx_q <= chk_idx_s1;
				match_amt_q <= rd_data[AMT_W-1:0];
			end
			if (!valid_q[chk_idx_s1] && !free_q) begin
				free_idx_q <= chk_idx_s1;
			end
		end
		if (state_q == capt_pkg::S_DECIDE) begin
			status_q <= status_d;
			freed_q  <= drop ? match_amt_q : '0;
		end
	end

	assign res.status          = status_q;
	assign res.available       = avail_now;
	assign res.used            = used_q;
	assign res.released_amount = freed_q;

endmodule

[design/per_owner_capacity_accounting_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-owner capacity accounting table
// Allocate and release requests scan every table entry, one read per entry,
//   before the decision; check and zero-amount allocate go straight to it.
// The result is registered before response valid. A new request is taken only
//   once the previous result has left the sequencer.
// Reset: clears entry valid bits and used total, total capacity to 4096.
// ----------------------------------------------------------------------------
module per_owner_capacity_accounting_table_unit #(
	parameter int TABLE_ENTRIES = 16,
	parameter int OWNER_ID_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [capt_pkg::AMOUNT_W-1:0] cfg_wr_data,
	capt_req_if.sink                      req,
	capt_rsp_if.source                    rsp
);

	localparam int IDX_W = TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1;
	localparam int ID_W  = OWNER_ID_BITS < capt_pkg::OWNER_W ? OWNER_ID_BITS : capt_pkg::OWNER_W;
	localparam int ENT_W = ID_W + capt_pkg::AMOUNT_W;

	logic [capt_pkg::AMOUNT_W-1:0] total_q;
	capt_pkg::rsp_t                res;
	capt_pkg::rsp_t                out_q;
	logic                          out_valid_q;
	logic                          res_valid;
	logic                          res_ready;
	logic                          rd_en;
	logic [IDX_W-1:0]              rd_addr;
	logic [ENT_W-1:0]              rd_data;
	logic                          wr_en;
	logic [IDX_W-1:0]              wr_addr;
	logic [ENT_W-1:0]              wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= capt_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			total_q <= cfg_wr_data;
		end
	end

	capt_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.ID_W          (ID_W)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.total_capacity (total_q),
		.res            (res),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.wr_en          (wr_en),
		.wr_addr        (wr_addr),
		.wr_data        (wr_data)
	);

	capt_mem #(
		.DEPTH (TABLE_ENTRIES),
		.WIDTH (ENT_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_q.status;
	assign rsp.available       = out_q.available;
	assign rsp.used            = out_q.used;
	assign rsp.released_amount = out_q.released_amount;

endmodule

[design/capt_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capacity table port checker
// Watches the top-level ports for response ordering and result consistency.
// ----------------------------------------------------------------------------
module capt_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_wr_en,
	input logic [capt_pkg::AMOUNT_W-1:0] cfg_wr_data,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [capt_pkg::STATUS_W-1:0] rsp_status,
	input logic [capt_pkg::AMOUNT_W-1:0] rsp_available,
	input logic [capt_pkg::AMOUNT_W-1:0] rsp_used,
	input logic [capt_pkg::AMOUNT_W-1:0] rsp_released_amount
);

	logic [capt_pkg::AMOUNT_W-1:0] tot_q;
	logic [1:0]                    pend_q;
	logic                          req_xfer;
	logic                          rsp_xfer;

	assign req_xfer = req_valid && req_ready;
	assign rsp_xfer = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q  <= capt_pkg::CAP_RESET;
			pend_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				tot_q <= cfg_wr_data;
			end
			if (req_xfer && !rsp_xfer) begin
				pend_q <= pend_q + 2'd1;
			end else if (rsp_xfer && !req_xfer) begin
				pend_q <= pend_q - 2'd1;
			end
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_used))
		else $error("response dropped or changed while stalled");

	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without an open request");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many requests in flight");

	a_avail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_available == ((tot_q >= rsp_used) ? (tot_q - rsp_used) : '0))
		else $error("available does not match total and used");

	a_freed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_released_amount != '0 |-> rsp_status == capt_pkg::ST_OK)
		else $error("released amount on a failed request");

endmodule

bind per_owner_capacity_accounting_table_unit capt_chk u_capt_chk (
	.clk                 (clk),
	.arst_n              (arst_n),
	.cfg_wr_en           (cfg_wr_en),
	.cfg_wr_data         (cfg_wr_data),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_status          (rsp.status),
	.rsp_available       (rsp.available),
	.rsp_used            (rsp.used),
	.rsp_released_amount (rsp.released_amount)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capacity table testbench
// Sends allocate, release, check and spare-opcode requests with random gaps and response
// stalls. Each response is compared against a behavioral model of the owner
// table, the used total and the total capacity. Directed tests first cover the
// refusal rules, a full table and extreme capacities. Random traffic then runs
// over several capacity settings.
// ----------------------------------------------------------------------------
module testbench;

	localparam int ENTRIES = 16;
	localparam int ID_BITS = 16;
	localparam logic [capt_pkg::OPCODE_W-1:0] OP_SPARE = 2'd3;
	localparam logic [capt_pkg::OWNER_W-1:0] OWNER_MASK =
		{capt_pkg::OWNER_W{1'b1}} >> (capt_pkg::OWNER_W - ID_BITS);
	localparam int SETTLE_CYCLES = ENTRIES + 8;
	localparam int STALL_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;
	localparam int POOL_SIZE = 24;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 130;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [capt_pkg::AMOUNT_W-1:0] cfg_wr_data;

	capt_req_if req_ch ();
	capt_rsp_if rsp_ch ();

	per_owner_capacity_accounting_table_unit #(
		.TABLE_ENTRIES(ENTRIES),
		.OWNER_ID_BITS(ID_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	logic                          slot_busy   [ENTRIES];
	logic [capt_pkg::OWNER_W-1:0]  slot_owner  [ENTRIES];
	logic [capt_pkg::AMOUNT_W-1:0] slot_amount [ENTRIES];
	logic [capt_pkg::AMOUNT_W-1:0] units_used;
	logic [capt_pkg::AMOUNT_W-1:0] units_total;
	logic [capt_pkg::OWNER_W-1:0]  owner_pool  [POOL_SIZE];

	capt_pkg::rsp_t booked_q [$];
	int   mismatches = 0;
	int   quiet_cycles = 0;
	bit   send_steady = 1'b0;
	bit   take_steady = 1'b0;

	always #6 clk = ~clk;

	function automatic logic [capt_pkg::AMOUNT_W-1:0] headroom();
		return (units_total >= units_used) ? units_total - units_used : '0;
	endfunction

	function automatic capt_pkg::rsp_t book_request(input logic [capt_pkg::OPCODE_W-1:0] op,
		input logic [capt_pkg::OWNER_W-1:0] owner, input logic [capt_pkg::AMOUNT_W-1:0] amt);
		capt_pkg::rsp_t r;
		int hit;
		int free_slot;
		logic [capt_pkg::OWNER_W-1:0] key;
		logic [capt_pkg::AMOUNT_W-1:0] freed;
		key = owner & OWNER_MASK;
		hit = -1;
		free_slot = -1;
		freed = '0;
		r.status = capt_pkg::ST_OK;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (slot_busy[i] && slot_owner[i] == key)
				hit = i;
			if (!slot_busy[i])
				free_slot = i;
		end
		case (op)
			capt_pkg::OP_ALLOC: begin
				if (amt == '0)
					r.status = capt_pkg::ST_ZERO_AMOUNT;
				else if (hit >= 0)
					r.status = capt_pkg::ST_ID_PRESENT;
				else if (headroom() < amt)
					r.status = capt_pkg::ST_INSUFFICIENT;
				else if (free_slot < 0)
					r.status = capt_pkg::ST_TABLE_FULL;
				else begin
					slot_busy[free_slot] = 1'b1;
					slot_owner[free_slot] = key;
					slot_amount[free_slot] = amt;
					units_used = units_used + amt;
				end
			end
			capt_pkg::OP_RELEASE: begin
				if (hit < 0)
					r.status = capt_pkg::ST_NOT_FOUND;
				else begin
					freed = slot_amount[hit];
					units_used = (units_used >= freed) ? units_used - freed : '0;
					slot_busy[hit] = 1'b0;
				end
			end
			default: begin
				r.status = (headroom() < amt) ? capt_pkg::ST_INSUFFICIENT : capt_pkg::ST_OK;
			end
		endcase
		r.available = headroom();
		r.used = units_used;
		r.released_amount = freed;
		return r;
	endfunction

	function automatic int draw_wait(inout bit steady);
		if ($urandom_range(0, 39) == 0)
			steady = !steady;
		return steady ? 0 : int'($urandom_range(0, 11));
	endfunction

	function automatic logic [capt_pkg::AMOUNT_W-1:0] draw_amount();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom;
			2: return headroom();
			3: return headroom() + 1'b1;
			default: return $urandom_range(1, (units_total >> 3) + 1);
		endcase
	endfunction

	task automatic send_request(input logic [capt_pkg::OPCODE_W-1:0] op,
		input logic [capt_pkg::OWNER_W-1:0] owner, input logic [capt_pkg::AMOUNT_W-1:0] amt);
		int gap;
		gap = draw_wait(send_steady);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.owner_id <= owner;
		req_ch.amount <= amt;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		booked_q.push_back(book_request(op, owner, amt));
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (booked_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [capt_pkg::AMOUNT_W-1:0] value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		units_total = value;
	endtask

	task automatic release_all();
		logic [capt_pkg::OWNER_W-1:0] owners [$];
		foreach (slot_busy[i])
			if (slot_busy[i])
				owners.push_back(slot_owner[i]);
		foreach (owners[k])
			send_request(capt_pkg::OP_RELEASE, owners[k], $urandom);
	endtask

	task automatic random_request();
		int pick;
		logic [capt_pkg::OPCODE_W-1:0] op;
		logic [capt_pkg::OWNER_W-1:0] owner;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			op = capt_pkg::OP_ALLOC;
		else if (pick < 80)
			op = capt_pkg::OP_RELEASE;
		else if (pick < 95)
			op = capt_pkg::OP_CHECK;
		else
			op = OP_SPARE;
		if ($urandom_range(0, 7) == 0)
			owner = capt_pkg::OWNER_W'($urandom);
		else
			owner = owner_pool[$urandom_range(0, POOL_SIZE - 1)];
		send_request(op, owner, draw_amount());
	endtask

	task automatic test_allocate_rules();
		send_request(capt_pkg::OP_ALLOC, 16'h0007, '0);
		send_request(capt_pkg::OP_CHECK, 16'h0000, '0);
		send_request(capt_pkg::OP_RELEASE, 16'h1234, 32'hFFFF_FFFF);
		send_request(capt_pkg::OP_ALLOC, 16'h0000, 32'd1);
		send_request(capt_pkg::OP_ALLOC, 16'h0000, 32'd5);
		send_request(capt_pkg::OP_ALLOC, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(capt_pkg::OP_CHECK, 16'hFFFF, 32'd4095);
		send_request(capt_pkg::OP_CHECK, 16'hFFFF, 32'd4096);
		send_request(OP_SPARE, 16'h00AA, 32'd4095);
		send_request(OP_SPARE, 16'h00AA, 32'd4096);
		send_request(capt_pkg::OP_RELEASE, 16'h0000, '0);
		send_request(capt_pkg::OP_RELEASE, 16'h0000, '0);
		for (int i = 1; i <= ENTRIES + 1; i++)
			send_request(capt_pkg::OP_ALLOC, capt_pkg::OWNER_W'(i), 32'd1);
	endtask

	task automatic test_capacity_extremes();
		set_capacity('0);
		send_request(capt_pkg::OP_CHECK, 16'h5555, '0);
		send_request(capt_pkg::OP_CHECK, 16'h5555, 32'd1);
		send_request(capt_pkg::OP_ALLOC, 16'h0100, 32'd1);
		send_request(capt_pkg::OP_RELEASE, 16'h0001, '0);
		set_capacity('1);
		send_request(capt_pkg::OP_ALLOC, 16'hFFFF, headroom());
		send_request(capt_pkg::OP_CHECK, 16'hFFFF, 32'hFFFF_FFFF);
		release_all();
		send_request(capt_pkg::OP_CHECK, 16'h0000, 32'hFFFF_FFFF);
		set_capacity(32'd1);
		send_request(capt_pkg::OP_ALLOC, 16'h8000, 32'd1);
		send_request(capt_pkg::OP_ALLOC, 16'h8001, 32'd1);
		release_all();
	endtask

	task automatic test_random_traffic();
		logic [capt_pkg::AMOUNT_W-1:0] cap;
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				case (phase)
					1: cap = '0;
					2: cap = 32'd1;
					3: cap = '1;
					4: cap = $urandom_range(16, 65535);
					6: cap = capt_pkg::CAP_RESET;
					7: cap = $urandom_range(1, 255);
					8: cap = '1;
					default: cap = $urandom;
				endcase
				if ($urandom_range(0, 2) == 0)
					release_all();
				set_capacity(cap);
			end
			repeat (PHASE_ITEMS) random_request();
		end
	endtask

	task automatic finish_run();
		wait_idle();
		if (mismatches == 0 && booked_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	endtask

	task automatic check_result();
		capt_pkg::rsp_t exp;
		if (booked_q.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("unexpected response: status %0d available %h used %h released %h",
					rsp_ch.status, rsp_ch.available, rsp_ch.used, rsp_ch.released_amount);
		end else begin
			exp = booked_q.pop_front();
			if (exp.status != rsp_ch.status || exp.available != rsp_ch.available ||
				exp.used != rsp_ch.used || exp.released_amount != rsp_ch.released_amount) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("mismatch: expected %0d/%h/%h/%h got %0d/%h/%h/%h",
						exp.status, exp.available, exp.used, exp.released_amount,
						rsp_ch.status, rsp_ch.available, rsp_ch.used,
						rsp_ch.released_amount);
			end
		end
	endtask

	initial begin : take_results
		int stall;
		forever begin
			stall = draw_wait(take_steady);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			check_result();
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < STALL_LIMIT) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= capt_pkg::OP_CHECK;
		req_ch.owner_id <= '0;
		req_ch.amount <= '0;
		foreach (slot_busy[i]) begin
			slot_busy[i] = 1'b0;
			slot_owner[i] = '0;
			slot_amount[i] = '0;
		end
		units_used = '0;
		units_total = capt_pkg::CAP_RESET;
		owner_pool[0] = '0;
		owner_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			owner_pool[i] = capt_pkg::OWNER_W'($urandom);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_allocate_rules();
		test_capacity_extremes();
		test_random_traffic();
		finish_run();
	end

endmodule
